>>> rtl/scaa_pkg.sv
// ----------------------------------------------------------------------------
// Sector cache aging allocator package
// Shared types and fixed field widths for the directory and its selector.
// ----------------------------------------------------------------------------
`default_nettype none

package scaa_pkg;

    localparam int ADDR_W       = 32;
    localparam int CFG_W        = 6;
    localparam int SLOT_IDX_W   = 5;
    localparam int TDATA_IN_W   = 32;
    localparam int TDATA_OUT_W  = 40;
    localparam int TUSER_OUT_W  = 2;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 6'd32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } scaa_state_t;

    typedef struct packed {
        logic clear;
        logic step;
        logic occupied;
    } scaa_scan_ctl_t;

endpackage

`default_nettype wire

>>> rtl/scaa_select.sv
// ----------------------------------------------------------------------------
// Sector cache aging allocator slot selector
// Accumulates hit, first empty slot and oldest victim over one directory scan.
// ----------------------------------------------------------------------------
`default_nettype none

module scaa_select #(
    parameter int SLOT_COUNT = 32,
    parameter int AGE_BITS   = 15,
    parameter int IW         = 5
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire scaa_pkg::scaa_scan_ctl_t    ctl,
    input  wire logic [IW-1:0]               idx,
    input  wire logic [scaa_pkg::ADDR_W-1:0] req_addr,
    input  wire logic [scaa_pkg::ADDR_W-1:0] entry_addr,
    input  wire logic [AGE_BITS-1:0]         entry_tag,
    output logic [IW-1:0]                    chosen_idx,
    output logic                             hit,
    output logic                             disp_valid,
    output logic [scaa_pkg::ADDR_W-1:0]      disp_addr
);
    import scaa_pkg::*;

    logic                hit_reg,          hit_next;
    logic [IW-1:0]       hit_idx_reg,      hit_idx_next;
    logic                empty_found_reg,  empty_found_next;
    logic [IW-1:0]       empty_idx_reg,    empty_idx_next;
    logic                victim_found_reg, victim_found_next;
    logic [IW-1:0]       victim_idx_reg,   victim_idx_next;
    logic [AGE_BITS-1:0] victim_tag_reg,   victim_tag_next;
    logic [ADDR_W-1:0]   victim_addr_reg,  victim_addr_next;

    always_comb begin
        hit_next          = hit_reg;
        hit_idx_next      = hit_idx_reg;
        empty_found_next  = empty_found_reg;
        empty_idx_next    = empty_idx_reg;
        victim_found_next = victim_found_reg;
        victim_idx_next   = victim_idx_reg;
        victim_tag_next   = victim_tag_reg;
        victim_addr_next  = victim_addr_reg;
        if (ctl.clear) begin
            hit_next          = 1'b0;
            empty_found_next  = 1'b0;
            victim_found_next = 1'b0;
        end else if (ctl.step) begin
            if (!ctl.occupied) begin
                if (!empty_found_reg) begin
                    empty_found_next = 1'b1;
                    empty_idx_next   = idx;
                end
            end else begin
                if (entry_addr == req_addr) begin
                    hit_next     = 1'b1;
                    hit_idx_next = idx;
                end
                if (!victim_found_reg || (entry_tag < victim_tag_reg)) begin
                    victim_found_next = 1'b1;
                    victim_idx_next   = idx;
                    victim_tag_next   = entry_tag;
                    victim_addr_next  = entry_addr;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg          <= 1'b0;
            empty_found_reg  <= 1'b0;
            victim_found_reg <= 1'b0;
        end else begin
            hit_reg          <= hit_next;
            empty_found_reg  <= empty_found_next;
            victim_found_reg <= victim_found_next;
        end
        hit_idx_reg     <= hit_idx_next;
        empty_idx_reg   <= empty_idx_next;
        victim_idx_reg  <= victim_idx_next;
        victim_tag_reg  <= victim_tag_next;
        victim_addr_reg <= victim_addr_next;
    end

    always_comb begin
        hit        = hit_reg;
        disp_valid = !hit_reg && !empty_found_reg;
        disp_addr  = disp_valid ? victim_addr_reg : '0;
        if (hit_reg) begin
            chosen_idx = hit_idx_reg;
        end else if (empty_found_reg) begin
            chosen_idx = empty_idx_reg;
        end else begin
            chosen_idx = victim_idx_reg;
        end
    end

`ifndef SYNTHESIS
    a_victim_tag_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        victim_found_reg && !ctl.clear |=> victim_found_reg
            && (victim_tag_reg <= $past(victim_tag_reg)))
        else $error("Victim age tag rose within a scan.");

    a_hit_on_match: assert property (@(posedge aclk) disable iff (!aresetn)
        !ctl.clear && ctl.step && ctl.occupied && (entry_addr == req_addr)
            |=> hit_reg && (hit_idx_reg == $past(idx)))
        else $error("Matching slot was not recorded as the hit.");

    a_empty_first: assert property (@(posedge aclk) disable iff (!aresetn)
        empty_found_reg && !ctl.clear |=> $stable(empty_idx_reg))
        else $error("First empty slot changed within a scan.");
`endif

endmodule

`default_nettype wire

>>> rtl/sector_cache_aging_allocator.sv
// ----------------------------------------------------------------------------
// Sector cache aging allocator
// Fully associative sector directory with aging replacement of slots.
// ----------------------------------------------------------------------------
//  Channel  Direction  Ports                          Contents
//  s_       in         s_tvalid s_tready s_tdata      sector address
//  m_       out        m_tvalid m_tready m_tdata      slot index, displaced address
//                      m_tuser                        hit, displaced valid
//  cfg_     in         cfg_we cfg_wdata               active entry count
//
// A request scans the directory memory one slot per cycle through its read port,
// covering n slots, n being the effective active entry count.
// Reset clears the occupancy flags at once; there is no clearing pass.
// A result waits in the output register while the next request is scanned;
// the scan holds in its last step only if that register is still full.
`default_nettype none

module sector_cache_aging_allocator #(
    parameter int SLOT_COUNT = 32,
    parameter int AGE_BITS   = 15
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [scaa_pkg::CFG_W-1:0]          cfg_wdata,   // active_entries
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [scaa_pkg::TDATA_IN_W-1:0]     s_tdata,     // [31:0] sector_address
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [4:0] slot_index, [36:5] displaced_address, [39:37] zero
    output logic [scaa_pkg::TDATA_OUT_W-1:0]         m_tdata,
    // [0] hit, [1] displaced_valid
    output logic [scaa_pkg::TUSER_OUT_W-1:0]         m_tuser
);
    import scaa_pkg::*;

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = (IW + 1 > CFG_W) ? IW + 1 : CFG_W;
    localparam int MW = ADDR_W + AGE_BITS;
    localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};
    localparam int PAD_W = TDATA_OUT_W - SLOT_IDX_W - ADDR_W;

    scaa_state_t       state_reg, state_next;
    logic [CFG_W-1:0]  active_reg;
    logic [IW-1:0]     scan_idx_reg, scan_idx_next;
    logic [IW-1:0]     last_idx_reg, last_idx_next;
    logic [ADDR_W-1:0] req_addr_reg;
    logic [SLOT_COUNT-1:0] occ_reg;

    logic [MW-1:0]     dir_mem [SLOT_COUNT];
    logic [MW-1:0]     rd_data_reg;
    logic [IW-1:0]     rd_idx;
    logic              mem_we;
    logic [IW-1:0]     wr_idx;
    logic [MW-1:0]     wr_data;

    logic [CW-1:0]     count_eff;
    logic              accept;
    logic              out_load;
    logic              out_free;

    logic [ADDR_W-1:0]   entry_addr;
    logic [AGE_BITS-1:0] entry_tag;
    logic [AGE_BITS-1:0] entry_tag_aged;
    logic                entry_occ;

    scaa_scan_ctl_t    scan_ctl;
    logic [IW-1:0]     chosen_idx;
    logic              sel_hit;
    logic              sel_disp_valid;
    logic [ADDR_W-1:0] sel_disp_addr;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [TDATA_OUT_W-1:0] m_tdata_reg;
    logic [TUSER_OUT_W-1:0] m_tuser_reg;

    assign entry_addr     = rd_data_reg[ADDR_W-1:0];
    assign entry_tag      = rd_data_reg[MW-1:ADDR_W];
    assign entry_tag_aged = (entry_tag == '0) ? '0 : entry_tag - AGE_BITS'(1);
    assign entry_occ      = occ_reg[scan_idx_reg];
    assign out_free       = !m_tvalid_reg || m_tready;

    always_comb begin
        count_eff = CW'(active_reg);
        if (count_eff == '0) begin
            count_eff = CW'(1);
        end else if (count_eff > CW'(SLOT_COUNT)) begin
            count_eff = CW'(SLOT_COUNT);
        end
        last_idx_next = IW'(count_eff - CW'(1));
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_idx_reg == last_idx_reg) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready          = 1'b0;
        out_load          = 1'b0;
        mem_we            = 1'b0;
        wr_idx            = scan_idx_reg;
        wr_data           = {entry_tag_aged, entry_addr};
        rd_idx            = scan_idx_reg + IW'(1);
        scan_ctl.clear    = 1'b0;
        scan_ctl.step     = 1'b0;
        scan_ctl.occupied = entry_occ;
        case (state_reg)
            ST_IDLE: begin
                s_tready       = 1'b1;
                rd_idx         = '0;
                scan_ctl.clear = 1'b1;
            end
            ST_SCAN: begin
                scan_ctl.step = 1'b1;
                mem_we        = entry_occ;
            end
            ST_FINISH: begin
                out_load = out_free;
                mem_we   = out_free;
                wr_idx   = chosen_idx;
                wr_data  = {AGE_MAX, req_addr_reg};
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_comb begin
        scan_idx_next = scan_idx_reg;
        if (accept) begin
            scan_idx_next = '0;
        end else if (state_reg == ST_SCAN) begin
            scan_idx_next = scan_idx_reg + IW'(1);
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            dir_mem[wr_idx] <= wr_data;
        end
        rd_data_reg <= dir_mem[rd_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            active_reg   <= ACTIVE_RESET;
            occ_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_we) begin
                active_reg <= cfg_wdata;
            end
            if (out_load) begin
                occ_reg[chosen_idx] <= 1'b1;
            end
        end
        scan_idx_reg <= scan_idx_next;
        if (accept) begin
            last_idx_reg <= last_idx_next;
            req_addr_reg <= s_tdata;
        end
        if (out_load) begin
            m_tdata_reg <= {{PAD_W{1'b0}}, sel_disp_addr, SLOT_IDX_W'(chosen_idx)};
            m_tuser_reg <= {sel_disp_valid, sel_hit};
        end
    end

    scaa_select #(
        .SLOT_COUNT (SLOT_COUNT),
        .AGE_BITS   (AGE_BITS),
        .IW         (IW)
    ) u_select (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (scan_ctl),
        .idx        (scan_idx_reg),
        .req_addr   (req_addr_reg),
        .entry_addr (entry_addr),
        .entry_tag  (entry_tag),
        .chosen_idx (chosen_idx),
        .hit        (sel_hit),
        .disp_valid (sel_disp_valid),
        .disp_addr  (sel_disp_addr)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_write_only_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg != ST_IDLE))
        else $error("Directory written while idle.");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (scan_idx_reg <= last_idx_reg))
        else $error("Scan index passed the last active slot.");

    a_accept_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_SCAN) && (scan_idx_reg == '0))
        else $error("Accepted transfer did not start a scan.");

    a_hit_no_displace: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tuser_reg[0] |-> !m_tuser_reg[1])
        else $error("Hit reported together with a displaced slot.");

    a_displaced_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tuser_reg[1]
            |-> (m_tdata_reg[SLOT_IDX_W +: ADDR_W] == '0))
        else $error("Displaced address not zero without a displaced slot.");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_sector_cache_aging_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sector cache aging allocator testbench
// This bench drives sector address lookups through the input stream. It keeps
// its own copy of the directory: occupancy, addresses and age tags. Every
// returned slot, hit flag and displaced address is checked against that copy.
// The active slot count is reprogrammed between phases of traffic. Random
// gaps and back-pressure are applied on both streams.
// ----------------------------------------------------------------------------
module tb_sector_cache_aging_allocator;
    import scaa_pkg::*;

    localparam int CLK_PERIOD = 4;
    localparam int SLOTS = 32;
    localparam int AGE_W = 15;
    localparam logic [AGE_W-1:0] AGE_MAX = '1;
    localparam int RANDOM_LOOKUPS = 850;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [SLOT_IDX_W-1:0] slot;
        logic                  hit;
        logic                  displaced;
        logic [ADDR_W-1:0]     displaced_addr;
    } lookup_result_t;

    typedef enum logic {ROW_CONFIG, ROW_LOOKUP} row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [ADDR_W-1:0] value;
        logic [15:0]       repeats;
        logic              typed;
        lookup_result_t    want;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 23;

    // The last lookups take the slot with the smallest tag rather than the
    // first occupied one. A slot left outside the active range keeps its tag,
    // so two slots end up tied and the lower one is taken.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_LOOKUP, 32'h0000_0000, 16'd1, 1'b1, '{5'd0, 1'b0, 1'b0, 32'h0}},
        '{ROW_LOOKUP, 32'hFFFF_FFFF, 16'd1, 1'b1, '{5'd1, 1'b0, 1'b0, 32'h0}},
        '{ROW_LOOKUP, 32'h0000_0000, 16'd1, 1'b1, '{5'd0, 1'b1, 1'b0, 32'h0}},
        '{ROW_CONFIG, 32'd1,         16'd1, 1'b0, '0},
        '{ROW_LOOKUP, 32'hAAAA_AAAA, 16'd1, 1'b1, '{5'd0, 1'b0, 1'b1, 32'h0}},
        '{ROW_LOOKUP, 32'h5555_5555, 16'd1, 1'b1, '{5'd0, 1'b0, 1'b1, 32'hAAAA_AAAA}},
        '{ROW_CONFIG, 32'd0,         16'd1, 1'b0, '0},
        '{ROW_LOOKUP, 32'h5555_5555, 16'd1, 1'b1, '{5'd0, 1'b1, 1'b0, 32'h0}},
        '{ROW_CONFIG, 32'd63,        16'd1, 1'b0, '0},
        '{ROW_LOOKUP, 32'hAAAA_AAAA, 16'd1, 1'b1, '{5'd2, 1'b0, 1'b0, 32'h0}},
        '{ROW_LOOKUP, 32'hFFFF_FFFF, 16'd1, 1'b1, '{5'd1, 1'b1, 1'b0, 32'h0}},
        '{ROW_CONFIG, 32'd2,         16'd1, 1'b0, '0},
        '{ROW_LOOKUP, 32'hAAAA_AAAA, 16'd1, 1'b1, '{5'd0, 1'b0, 1'b1, 32'h5555_5555}},
        '{ROW_CONFIG, 32'd33,        16'd1, 1'b0, '0},
        '{ROW_LOOKUP, 32'hAAAA_AAAA, 16'd1, 1'b1, '{5'd2, 1'b1, 1'b0, 32'h0}},
        '{ROW_CONFIG, 32'd3,         16'd1, 1'b0, '0},
        '{ROW_LOOKUP, 32'h1234_5678, 16'd1, 1'b1, '{5'd1, 1'b0, 1'b1, 32'hFFFF_FFFF}},
        '{ROW_LOOKUP, 32'h8765_4321, 16'd1, 1'b1, '{5'd0, 1'b0, 1'b1, 32'hAAAA_AAAA}},
        '{ROW_CONFIG, 32'd2,         16'd1, 1'b0, '0},
        '{ROW_LOOKUP, 32'h8765_4321, 16'd1, 1'b1, '{5'd0, 1'b1, 1'b0, 32'h0}},
        '{ROW_CONFIG, 32'd3,         16'd1, 1'b0, '0},
        '{ROW_LOOKUP, 32'h0F0F_0F0F, 16'd1, 1'b1, '{5'd1, 1'b0, 1'b1, 32'h1234_5678}},
        '{ROW_CONFIG, 32'd32,        16'd1, 1'b0, '0}
    };

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_W-1:0]       cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic [TUSER_OUT_W-1:0] m_tuser;

    logic [CFG_W-1:0]  active_reg = ACTIVE_RESET;
    bit                dir_occupied [SLOTS];
    logic [ADDR_W-1:0] dir_addr [SLOTS];
    logic [AGE_W-1:0]  dir_age [SLOTS];

    lookup_result_t pending_results [$];
    int unsigned    mismatches = 0;
    int unsigned    results_seen = 0;
    int unsigned    results_paced = 0;
    int unsigned    ready_hold = 0;
    int unsigned    quiet_cycles = 0;
    bit             no_idle = 1'b0;

    sector_cache_aging_allocator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic lookup_result_t allocate_slot(input logic [ADDR_W-1:0] addr);
        lookup_result_t   res;
        int unsigned      in_use;
        bit               found;
        bit               have_free;
        bit               have_oldest;
        int unsigned      match_idx;
        int unsigned      free_idx;
        int unsigned      oldest_idx;
        int unsigned      chosen;
        logic [AGE_W-1:0] oldest_age;
        in_use = (active_reg == 0) ? 1 : (active_reg > SLOTS) ? SLOTS : active_reg;
        found = 1'b0;
        have_free = 1'b0;
        have_oldest = 1'b0;
        match_idx = 0;
        free_idx = 0;
        oldest_idx = 0;
        oldest_age = '0;
        res = '0;
        for (int i = 0; i < in_use; i++) begin
            if (!dir_occupied[i]) begin
                if (!have_free) begin
                    have_free = 1'b1;
                    free_idx = i;
                end
            end else begin
                if (dir_addr[i] == addr) begin
                    found = 1'b1;
                    match_idx = i;
                end
                if (!have_oldest || dir_age[i] < oldest_age) begin
                    have_oldest = 1'b1;
                    oldest_idx = i;
                    oldest_age = dir_age[i];
                end
                if (dir_age[i] != 0)
                    dir_age[i] = dir_age[i] - 1'b1;
            end
        end
        if (found) begin
            chosen = match_idx;
            res.hit = 1'b1;
        end else if (have_free) begin
            chosen = free_idx;
        end else begin
            chosen = oldest_idx;
            res.displaced = 1'b1;
            res.displaced_addr = dir_addr[chosen];
        end
        if (!found) begin
            dir_occupied[chosen] = 1'b1;
            dir_addr[chosen] = addr;
        end
        dir_age[chosen] = AGE_MAX;
        res.slot = chosen[SLOT_IDX_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                   input logic [ADDR_W-1:0] wanted);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("%0t ns mismatch on %s: got %h, wanted %h", $time, what, got, wanted);
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_lookup(input logic [ADDR_W-1:0] addr, input bit use_want,
                               input lookup_result_t want);
        int unsigned    gap;
        lookup_result_t predicted;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= addr;
        do @(posedge aclk); while (!s_tready);
        predicted = allocate_slot(addr);
        pending_results.push_back(use_want ? want : predicted);
        @(negedge aclk);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic program_active(input logic [CFG_W-1:0] setting);
        wait_for_results();
        cfg_we <= 1'b1;
        cfg_wdata <= setting;
        @(posedge aclk);
        active_reg = setting;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    always @(posedge aclk) begin
        lookup_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with no lookup outstanding", m_tdata[31:0], '0);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[SLOT_IDX_W-1:0] != want.slot)
                    report_mismatch("slot_index", ADDR_W'(m_tdata[SLOT_IDX_W-1:0]),
                                    ADDR_W'(want.slot));
                if (m_tuser[0] != want.hit)
                    report_mismatch("hit", ADDR_W'(m_tuser[0]), ADDR_W'(want.hit));
                if (m_tuser[1] != want.displaced)
                    report_mismatch("displaced_valid", ADDR_W'(m_tuser[1]),
                                    ADDR_W'(want.displaced));
                if (m_tdata[SLOT_IDX_W +: ADDR_W] != want.displaced_addr)
                    report_mismatch("displaced_address", m_tdata[SLOT_IDX_W +: ADDR_W],
                                    want.displaced_addr);
            end
        end
    end

    always @(negedge aclk) begin
        if (results_seen != results_paced) begin
            results_paced = results_seen;
            ready_hold = no_idle ? 0 : $urandom_range(0, 4);
        end
        if (ready_hold != 0) begin
            m_tready <= 1'b0;
            ready_hold--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int unsigned       random_sent;
        int unsigned       phase_no;
        int unsigned       phase_len;
        int unsigned       pool_size;
        int unsigned       pick;
        logic [ADDR_W-1:0] addr_pool [40];
        logic [ADDR_W-1:0] addr;
        logic [CFG_W-1:0]  setting;
        random_sent = 0;
        phase_no = 0;
        foreach (dir_occupied[i])
            dir_occupied[i] = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CONFIG) begin
                program_active(directed_rows[i].value[CFG_W-1:0]);
            end else begin
                no_idle = directed_rows[i].repeats > 1;
                repeat (directed_rows[i].repeats)
                    send_lookup(directed_rows[i].value, directed_rows[i].typed,
                                directed_rows[i].want);
            end
        end

        while (random_sent < RANDOM_LOOKUPS) begin
            no_idle = 1'b0;
            case ($urandom_range(0, 4))
                0: setting = CFG_W'($urandom_range(0, 63));
                1: setting = CFG_W'($urandom_range(1, 4));
                2: setting = CFG_W'($urandom_range(29, 34));
                3: setting = ACTIVE_RESET;
                default: setting = $urandom_range(0, 1) ? 6'd63 : 6'd0;
            endcase
            program_active(setting);
            no_idle = $urandom_range(0, 3) == 0;
            phase_len = $urandom_range(10, 60);
            pool_size = $urandom_range(1, 40);
            for (int j = 0; j < pool_size; j++)
                addr_pool[j] = $urandom;
            for (int k = 0; k < phase_len; k++) begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    addr = addr_pool[$urandom_range(0, pool_size - 1)];
                else if (pick < 9)
                    addr = $urandom;
                else
                    addr = (32'h1 << $urandom_range(0, 31))
                           ^ ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0);
                send_lookup(addr, 1'b0, '0);
                random_sent++;
                if (k == phase_len / 2 && phase_no % 3 == 0)
                    wait_for_results();
            end
            phase_no++;
        end

        no_idle = 1'b0;
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
